FILE: rtl/hsl2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

    // number of color channels and their lane order
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // 1.0 in the Q1.16 input format
    localparam logic [16:0] IN_ONE = 17'h10000;

    // segment of the hue ramp that a channel falls in
    typedef enum logic [1:0] {
        REGION_RISE = 2'd0,
        REGION_TOP  = 2'd1,
        REGION_FALL = 2'd2,
        REGION_BASE = 2'd3
    } hsl2rgb_region_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } hsl2rgb_stage_en_t;

endpackage

`default_nettype wire

FILE: rtl/hsl_to_rgb_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// HSL to 8-bit RGB converter. Hue is an unsigned Q0.16 fraction of a turn;
// saturation and lightness are unsigned Q1.16 (65536 = 1.0, larger values
// clamp to 1.0). Each channel is the standard piecewise hue ramp scaled by
// 255, truncated and clipped to a byte; zero saturation gives grey. The
// block takes one color every clock cycle while s_ready is high and passes
// it through a four-stage pipeline (rescale and l*s, p/q and ramp segment,
// ramp multiply, scale to byte). A stall on m_ready holds each stage in
// place and empty stages still fill, so s_ready stays high until all four
// stages hold a color. FRAC_BITS sets the internal fraction width.
module hsl_to_rgb_converter_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_hue,
    input  wire logic [16:0] s_saturation,
    input  wire logic [16:0] s_lightness,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_blue_out
);
    import hsl2rgb_pkg::*;

    // pipeline valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    hsl2rgb_stage_en_t stage_en;

    always_comb begin
        rdy4 = !v4_reg || m_ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;

        stage_en.s1 = rdy1 && s_valid;
        stage_en.s2 = rdy2 && v1_reg;
        stage_en.s3 = rdy3 && v2_reg;
        stage_en.s4 = rdy4 && v3_reg;

        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
        v4_next = rdy4 ? v3_reg  : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    // shared front end
    hsl2rgb_region_t             region [NUM_CH];
    logic [FRAC_BITS:0]          slope_m [NUM_CH];
    logic signed [FRAC_BITS+1:0] base_p;
    logic [FRAC_BITS:0]          span_d;

    hsl2rgb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .hue        (s_hue),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .region     (region),
        .slope_m    (slope_m),
        .base_p     (base_p),
        .span_d     (span_d)
    );

    // one ramp lane per color channel
    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_red (
        .aclk     (aclk),
        .stage_en (stage_en),
        .region   (region[CH_RED]),
        .slope_m  (slope_m[CH_RED]),
        .base_p   (base_p),
        .span_d   (span_d),
        .chan_out (m_red_out)
    );

    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_green (
        .aclk     (aclk),
        .stage_en (stage_en),
        .region   (region[CH_GREEN]),
        .slope_m  (slope_m[CH_GREEN]),
        .base_p   (base_p),
        .span_d   (span_d),
        .chan_out (m_green_out)
    );

    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blue (
        .aclk     (aclk),
        .stage_en (stage_en),
        .region   (region[CH_BLUE]),
        .slope_m  (slope_m[CH_BLUE]),
        .base_p   (base_p),
        .span_d   (span_d),
        .chan_out (m_blue_out)
    );

endmodule

`default_nettype wire

FILE: rtl/hsl2rgb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire hsl2rgb_pkg::hsl2rgb_stage_en_t stage_en,
    input  wire logic [15:0]                   hue,
    input  wire logic [16:0]                   saturation,
    input  wire logic [16:0]                   lightness,
    output hsl2rgb_pkg::hsl2rgb_region_t       region [hsl2rgb_pkg::NUM_CH],
    output logic [FRAC_BITS:0]                 slope_m [hsl2rgb_pkg::NUM_CH],
    output logic signed [FRAC_BITS+1:0]        base_p,
    output logic [FRAC_BITS:0]                 span_d
);
    import hsl2rgb_pkg::*;

    localparam int UP_SHIFT   = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int DOWN_SHIFT = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
    localparam int EXT_W      = 17 + UP_SHIFT;
    localparam int HUE_EXT_W  = 16 + UP_SHIFT;

    localparam logic [FRAC_BITS:0] FX_ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] FX_SIXTH      = (FRAC_BITS+1)'(FX_ONE / 6);
    localparam logic [FRAC_BITS:0] FX_THIRD      = (FRAC_BITS+1)'(FX_ONE / 3);
    localparam logic [FRAC_BITS:0] FX_HALF       = (FRAC_BITS+1)'(FX_ONE / 2);
    localparam logic [FRAC_BITS:0] FX_TWO_THIRDS = (FRAC_BITS+1)'((2 * FX_ONE) / 3);
    localparam logic [FRAC_BITS:0] FX_BLUE_OFS   = FX_ONE - FX_THIRD;

    // stage 1 combinational: clamp, rescale, l*s, hue offsets
    logic [16:0]              s_clamp;
    logic [16:0]              l_clamp;
    logic [EXT_W-1:0]         s_ext;
    logic [EXT_W-1:0]         l_ext;
    logic [HUE_EXT_W-1:0]     h_ext;
    logic [FRAC_BITS:0]       s_int;
    logic [FRAC_BITS:0]       l_int;
    logic [FRAC_BITS-1:0]     h_int;
    logic [2*FRAC_BITS+1:0]   ls_prod;
    logic [FRAC_BITS-1:0]     t_next [NUM_CH];

    always_comb begin
        s_clamp = (saturation > IN_ONE) ? IN_ONE : saturation;
        l_clamp = (lightness > IN_ONE) ? IN_ONE : lightness;
        s_ext   = EXT_W'(s_clamp) << UP_SHIFT;
        l_ext   = EXT_W'(l_clamp) << UP_SHIFT;
        h_ext   = HUE_EXT_W'(hue) << UP_SHIFT;
        s_int   = (FRAC_BITS+1)'(s_ext >> DOWN_SHIFT);
        l_int   = (FRAC_BITS+1)'(l_ext >> DOWN_SHIFT);
        // hue has no integer bit; it is already a fraction of one turn
        h_int   = FRAC_BITS'(h_ext >> DOWN_SHIFT);
        ls_prod = (2*FRAC_BITS+2)'(l_int) * (2*FRAC_BITS+2)'(s_int);
        t_next[CH_RED]   = FRAC_BITS'((FRAC_BITS+1)'(h_int) + FX_THIRD);
        t_next[CH_GREEN] = h_int;
        t_next[CH_BLUE]  = FRAC_BITS'((FRAC_BITS+1)'(h_int) + FX_BLUE_OFS);
    end

    // stage 1 registers
    logic [FRAC_BITS:0]   l1_reg;
    logic [FRAC_BITS:0]   s1_reg;
    logic [FRAC_BITS:0]   ls1_reg;
    logic [FRAC_BITS-1:0] t1_reg [NUM_CH];

    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            l1_reg  <= l_int;
            s1_reg  <= s_int;
            ls1_reg <= ls_prod[2*FRAC_BITS:FRAC_BITS];
            for (int c = 0; c < NUM_CH; c++) begin
                t1_reg[c] <= t_next[c];
            end
        end
    end

    // stage 2 combinational: p, q - p and ramp segment per channel
    logic                          low_half;
    logic                          grey;
    logic signed [FRAC_BITS+2:0]   l_s;
    logic signed [FRAC_BITS+2:0]   s_s;
    logic signed [FRAC_BITS+2:0]   ls_s;
    logic signed [FRAC_BITS+2:0]   p_wide;
    logic [FRAC_BITS:0]            s_minus_ls;
    logic [FRAC_BITS+1:0]          d_wide;
    logic signed [FRAC_BITS+1:0]   p_next;
    logic [FRAC_BITS:0]            d_next;
    hsl2rgb_region_t               region_next [NUM_CH];
    logic [FRAC_BITS:0]            m_next [NUM_CH];
    logic [FRAC_BITS:0]            t_ext;
    logic [FRAC_BITS:0]            fall_x;
    logic [FRAC_BITS+3:0]          six_x;

    always_comb begin
        low_half   = l1_reg < FX_HALF;
        grey       = s1_reg == '0;
        l_s        = signed'((FRAC_BITS+3)'(l1_reg));
        s_s        = signed'((FRAC_BITS+3)'(s1_reg));
        ls_s       = signed'((FRAC_BITS+3)'(ls1_reg));
        s_minus_ls = s1_reg - ls1_reg;
        if (low_half) begin
            p_wide = l_s - ls_s;
            d_wide = {ls1_reg, 1'b0};
        end else begin
            p_wide = l_s - s_s + ls_s;
            d_wide = {s_minus_ls, 1'b0};
        end
        // grey: the base segment returns p, so p carries lightness
        p_next = grey ? signed'((FRAC_BITS+2)'(l1_reg)) : p_wide[FRAC_BITS+1:0];
        d_next = d_wide[FRAC_BITS:0];

        for (int c = 0; c < NUM_CH; c++) begin
            t_ext  = (FRAC_BITS+1)'(t1_reg[c]);
            fall_x = FX_TWO_THIRDS - t_ext;
            six_x  = (FRAC_BITS+4)'(t_ext);
            m_next[c] = '0;
            if (grey) begin
                region_next[c] = REGION_BASE;
            end else if (t_ext < FX_SIXTH) begin
                region_next[c] = REGION_RISE;
                six_x          = (FRAC_BITS+4)'(t_ext);
                m_next[c]      = (FRAC_BITS+1)'((six_x << 2) + (six_x << 1));
            end else if (t_ext < FX_HALF) begin
                region_next[c] = REGION_TOP;
            end else if (t_ext < FX_TWO_THIRDS) begin
                region_next[c] = REGION_FALL;
                six_x          = (FRAC_BITS+4)'(fall_x);
                m_next[c]      = (FRAC_BITS+1)'((six_x << 2) + (six_x << 1));
            end else begin
                region_next[c] = REGION_BASE;
            end
        end
    end

    // stage 2 registers
    hsl2rgb_region_t             region_reg [NUM_CH];
    logic [FRAC_BITS:0]          m_reg [NUM_CH];
    logic signed [FRAC_BITS+1:0] p_reg;
    logic [FRAC_BITS:0]          d_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s2) begin
            p_reg <= p_next;
            d_reg <= d_next;
            for (int c = 0; c < NUM_CH; c++) begin
                region_reg[c] <= region_next[c];
                m_reg[c]      <= m_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            region[c]  = region_reg[c];
            slope_m[c] = m_reg[c];
        end
    end

    assign base_p = p_reg;
    assign span_d = d_reg;

endmodule

`default_nettype wire

FILE: rtl/hsl2rgb_channel.sv
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_channel #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire hsl2rgb_pkg::hsl2rgb_stage_en_t stage_en,
    input  wire hsl2rgb_pkg::hsl2rgb_region_t   region,
    input  wire logic [FRAC_BITS:0]             slope_m,
    input  wire logic signed [FRAC_BITS+1:0]    base_p,
    input  wire logic [FRAC_BITS:0]             span_d,
    output logic [7:0]                          chan_out
);
    import hsl2rgb_pkg::*;

    // stage 3: ramp product and segment select
    logic [2*FRAC_BITS+1:0] ramp_prod;
    logic [FRAC_BITS:0]     term_next;

    always_comb begin
        ramp_prod = (2*FRAC_BITS+2)'(span_d) * (2*FRAC_BITS+2)'(slope_m);
        unique case (region) inside
            REGION_RISE,
            REGION_FALL: term_next = ramp_prod[2*FRAC_BITS:FRAC_BITS];
            REGION_TOP:  term_next = span_d;
            default:     term_next = '0;
        endcase
    end

    logic [FRAC_BITS:0]          term_reg;
    logic signed [FRAC_BITS+1:0] p3_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            term_reg <= term_next;
            p3_reg   <= base_p;
        end
    end

    // stage 4: channel value, scale by 255, clip to a byte
    logic signed [FRAC_BITS+2:0] value;
    logic [FRAC_BITS+1:0]        value_u;
    logic [FRAC_BITS+9:0]        scaled;
    logic [9:0]                  chan_wide;
    logic [7:0]                  byte_next;

    always_comb begin
        value     = (FRAC_BITS+3)'(p3_reg) + signed'((FRAC_BITS+3)'(term_reg));
        value_u   = value[FRAC_BITS+1:0];
        scaled    = {value_u, 8'b0} - (FRAC_BITS+10)'(value_u);
        chan_wide = scaled[FRAC_BITS+9:FRAC_BITS];
        if (value[FRAC_BITS+2] || value == '0) begin
            byte_next = '0;
        end else if (chan_wide > 10'd255) begin
            byte_next = 8'hFF;
        end else begin
            byte_next = chan_wide[7:0];
        end
    end

    logic [7:0] chan_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s4) begin
            chan_reg <= byte_next;
        end
    end

    assign chan_out = chan_reg;

endmodule

`default_nettype wire
